@@ sv/pps_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Preemptive priority scheduler package
// Table geometry, operation and status codes, and the task entry layout.
// ----------------------------------------------------------------------------
package pps_pkg;

	// Task table geometry.
	localparam int MAX_TASKS = 32;
	localparam int SLOT_W    = $clog2(MAX_TASKS);
	localparam int CNT_W     = $clog2(MAX_TASKS + 1);

	// Operation codes on the mode field.
	localparam logic [1:0] MODE_LOAD  = 2'd0;
	localparam logic [1:0] MODE_TICK  = 2'd1;
	localparam logic [1:0] MODE_CLEAR = 2'd2;

	// Result status codes.
	localparam logic [1:0] STAT_DONE = 2'd0;
	localparam logic [1:0] STAT_RAN  = 2'd1;
	localparam logic [1:0] STAT_IDLE = 2'd2;
	localparam logic [1:0] STAT_FULL = 2'd3;

	// Highest clock value; the clock saturates here.
	localparam logic [15:0] CLOCK_MAX = 16'hFFFF;

	// One task table entry.
	typedef struct packed {
		logic [15:0] id;
		logic [15:0] arrival;
		logic [15:0] burst;
		logic [15:0] remaining;
		logic [7:0]  prio;
	} slot_t;

endpackage
`default_nettype wire

@@ sv/preemptive_priority_scheduler_top.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Preemptive priority scheduler
// Task table in one synchronous RAM; a tick scans it one slot per cycle and
// runs one time unit of the most urgent ready task.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake            Payload
//  -------   ------------------   ---------------------------------------------
//  command   start / busy         mode, new_id, new_arrival, new_burst,
//                                 new_priority
//  result    done (one cycle)     status, running_id, switched, tick_start,
//                                 completed, turnaround, wait_time
//
// A load, clear or unused command keeps busy low and its result shows on the
// next cycle. A tick holds busy while it issues one RAM read per table slot,
// drains the read pipeline and writes back the chosen slot; its result shows
// in the first cycle with busy low again.
// Reset empties the table and zeroes the clock; the RAM itself is not
// cleared. Results are taken by the receiver in the cycle they show.
//
module preemptive_priority_scheduler_top
	import pps_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [1:0]  mode,
	input  wire logic [15:0] new_id,
	input  wire logic [15:0] new_arrival,
	input  wire logic [15:0] new_burst,
	input  wire logic [7:0]  new_priority,
	output logic             done,
	output logic [1:0]       status,
	output logic [15:0]      running_id,
	output logic             switched,
	output logic [15:0]      tick_start,
	output logic             completed,
	output logic [15:0]      turnaround,
	output logic [15:0]      wait_time
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DECIDE
	} state_t;

	state_t            state_q;
	logic [CNT_W-1:0]  count_q;
	logic [15:0]       clock_q;
	logic [SLOT_W-1:0] last_slot_q;
	logic              last_busy_q;

	// Scan pointer and read pipeline.
	logic [CNT_W-1:0]  idx_q;
	logic              rd_vld_s1;
	logic [SLOT_W-1:0] rd_slot_s1;
	slot_t             rd_data_s1;

	// Best candidate found so far in the current scan.
	logic              best_vld_q;
	logic [SLOT_W-1:0] best_slot_q;
	slot_t             best_q;

	// RAM ports.
	slot_t             mem [MAX_TASKS];
	logic              mem_we;
	logic [SLOT_W-1:0] mem_waddr;
	slot_t             mem_wdata;
	logic [SLOT_W-1:0] mem_raddr;

	logic              accept;
	logic              cand_ready;
	logic              cand_beats;
	logic              table_full;
	logic [15:0]       tick_end;
	logic [15:0]       rem_next;
	logic [15:0]       ta_calc;
	logic [15:0]       wt_calc;

	assign busy       = (state_q != ST_IDLE);
	assign accept     = start && !busy;
	assign table_full = (count_q == CNT_W'(MAX_TASKS));

	// Task table RAM with a registered read port.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		rd_data_s1 <= mem[mem_raddr];
	end

	// Write port: a load fills the next free slot, a tick writes back the winner.
	always_comb begin
		mem_raddr = idx_q[SLOT_W-1:0];
		if (state_q == ST_DECIDE) begin
			mem_we              = best_vld_q;
			mem_waddr           = best_slot_q;
			mem_wdata           = best_q;
			mem_wdata.remaining = rem_next;
		end else begin
			mem_we              = accept && (mode == MODE_LOAD) && !table_full;
			mem_waddr           = count_q[SLOT_W-1:0];
			mem_wdata.id        = new_id;
			mem_wdata.arrival   = new_arrival;
			mem_wdata.burst     = new_burst;
			mem_wdata.remaining = new_burst;
			mem_wdata.prio      = new_priority;
		end
	end

	// Candidate test: ready, and strictly more urgent than the current best.
	always_comb begin
		cand_ready = (rd_data_s1.arrival <= clock_q) && (rd_data_s1.remaining != 16'd0);
		if (rd_data_s1.prio != best_q.prio) begin
			cand_beats = rd_data_s1.prio < best_q.prio;
		end else if (rd_data_s1.arrival != best_q.arrival) begin
			cand_beats = rd_data_s1.arrival < best_q.arrival;
		end else begin
			cand_beats = rd_data_s1.id < best_q.id;
		end
	end

	// Completion arithmetic for the chosen task.
	always_comb begin
		tick_end = (clock_q == CLOCK_MAX) ? clock_q : clock_q + 16'd1;
		rem_next = best_q.remaining - 16'd1;
		ta_calc  = tick_end - best_q.arrival;
		wt_calc  = (ta_calc > best_q.burst) ? ta_calc - best_q.burst : 16'd0;
	end

	// Sequencer, scheduler state and registered result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			clock_q     <= '0;
			last_slot_q <= '0;
			last_busy_q <= 1'b0;
			idx_q       <= '0;
			rd_vld_s1   <= 1'b0;
			rd_slot_s1  <= '0;
			best_vld_q  <= 1'b0;
			best_slot_q <= '0;
			best_q      <= '0;
			done        <= 1'b0;
			status      <= STAT_DONE;
			running_id  <= '0;
			switched    <= 1'b0;
			tick_start  <= '0;
			completed   <= 1'b0;
			turnaround  <= '0;
			wait_time   <= '0;
		end else begin
			done <= 1'b0;

			// Keep the best candidate as read data comes back.
			if (rd_vld_s1 && cand_ready && (!best_vld_q || cand_beats)) begin
				best_vld_q  <= 1'b1;
				best_slot_q <= rd_slot_s1;
				best_q      <= rd_data_s1;
			end

			case (state_q)
				ST_IDLE: begin
					rd_vld_s1 <= 1'b0;
					if (accept) begin
						status     <= STAT_DONE;
						running_id <= '0;
						switched   <= 1'b0;
						tick_start <= '0;
						completed  <= 1'b0;
						turnaround <= '0;
						wait_time  <= '0;
						case (mode)
							MODE_LOAD: begin
								done <= 1'b1;
								if (table_full) begin
									status <= STAT_FULL;
								end else begin
									count_q <= count_q + CNT_W'(1);
								end
							end
							MODE_TICK: begin
								idx_q      <= '0;
								best_vld_q <= 1'b0;
								state_q    <= ST_SCAN;
							end
							MODE_CLEAR: begin
								done        <= 1'b1;
								count_q     <= '0;
								clock_q     <= '0;
								last_slot_q <= '0;
								last_busy_q <= 1'b0;
							end
							default: begin
								done <= 1'b1;
							end
						endcase
					end
				end
				ST_SCAN: begin
					// One slot read per cycle; the last one is compared on exit.
					if (idx_q < count_q) begin
						rd_vld_s1  <= 1'b1;
						rd_slot_s1 <= idx_q[SLOT_W-1:0];
						idx_q      <= idx_q + CNT_W'(1);
					end else begin
						rd_vld_s1 <= 1'b0;
						state_q   <= ST_DECIDE;
					end
				end
				ST_DECIDE: begin
					done       <= 1'b1;
					tick_start <= clock_q;
					clock_q    <= tick_end;
					state_q    <= ST_IDLE;
					if (best_vld_q) begin
						status      <= STAT_RAN;
						running_id  <= best_q.id;
						switched    <= !last_busy_q || (last_slot_q != best_slot_q);
						completed   <= (rem_next == 16'd0);
						turnaround  <= (rem_next == 16'd0) ? ta_calc : 16'd0;
						wait_time   <= (rem_next == 16'd0) ? wt_calc : 16'd0;
						last_slot_q <= best_slot_q;
						last_busy_q <= 1'b1;
					end else begin
						status      <= STAT_IDLE;
						last_busy_q <= 1'b0;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

@@ sv/pps_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Preemptive priority scheduler checker
// Port-level properties of the scheduler, bound to the top level.
// ----------------------------------------------------------------------------
module pps_checker
	import pps_pkg::*;
(
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        start,
	input wire logic        busy,
	input wire logic [1:0]  mode,
	input wire logic        done,
	input wire logic [1:0]  status,
	input wire logic [15:0] running_id,
	input wire logic        switched,
	input wire logic        completed,
	input wire logic [15:0] turnaround,
	input wire logic [15:0] wait_time
);

	// A command other than a tick delivers its result on the next cycle.
	a_quick_result: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (mode != MODE_TICK)) |=> done)
		else $error("non-tick command gave no result on the next cycle");

	// Only a tick that ran a task can report a completion or a switch.
	a_flags_need_run: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (completed || switched)) |-> (status == STAT_RAN))
		else $error("completion or switch reported without a task running");

	// An idle tick names no task.
	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (status == STAT_IDLE)) |-> (running_id == 16'd0))
		else $error("idle tick reported a task id");

	// Timing figures only accompany a completion.
	a_times_on_completion: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !completed) |-> ((turnaround == 16'd0) && (wait_time == 16'd0)))
		else $error("timing figures reported without a completion");

	// Waiting time never exceeds the turnaround time.
	a_wait_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		(done && completed) |-> (wait_time <= turnaround))
		else $error("wait time exceeds turnaround time");

endmodule

bind preemptive_priority_scheduler_top pps_checker u_pps_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.start      (start),
	.busy       (busy),
	.mode       (mode),
	.done       (done),
	.status     (status),
	.running_id (running_id),
	.switched   (switched),
	.completed  (completed),
	.turnaround (turnaround),
	.wait_time  (wait_time)
);
`default_nettype wire

@@ sim/pps_result_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Scheduler result checker
// Watches the command and result channels of the priority scheduler, keeps
// its own copy of the task table and clock, works out the outcome of every
// accepted command and compares each result transfer with the oldest one.
// ----------------------------------------------------------------------------
module pps_result_checker
	import pps_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic        busy,
	input  wire logic [1:0]  mode,
	input  wire logic [15:0] new_id,
	input  wire logic [15:0] new_arrival,
	input  wire logic [15:0] new_burst,
	input  wire logic [7:0]  new_priority,
	input  wire logic        done,
	input  wire logic [1:0]  status,
	input  wire logic [15:0] running_id,
	input  wire logic        switched,
	input  wire logic [15:0] tick_start,
	input  wire logic        completed,
	input  wire logic [15:0] turnaround,
	input  wire logic [15:0] wait_time,
	output int               mismatch_count,
	output int               outstanding
);

	// One result transfer, field for field.
	typedef struct packed {
		logic [1:0]  status;
		logic [15:0] running_id;
		logic        switched;
		logic [15:0] tick_start;
		logic        completed;
		logic [15:0] turnaround;
		logic [15:0] wait_time;
	} outcome_t;

	// One task as the predictor keeps it.
	typedef struct packed {
		logic [15:0] id;
		logic [15:0] arrival;
		logic [15:0] burst;
		logic [15:0] remaining;
		logic [7:0]  urgency;
	} task_entry_t;

	task_entry_t       task_table [MAX_TASKS];
	int                loaded_tasks;
	logic [15:0]       sched_clock;
	logic [SLOT_W-1:0] prev_slot;
	logic              prev_busy;
	outcome_t          expected_outcomes [$];
	outcome_t          want;
	outcome_t          got;

	// True when task a should run ahead of task b, which sits in a lower slot.
	function automatic bit outranks(task_entry_t a, task_entry_t b);
		if (a.urgency != b.urgency)
			return a.urgency < b.urgency;
		if (a.arrival != b.arrival)
			return a.arrival < b.arrival;
		return a.id < b.id;
	endfunction

	// Applies one command to the table and returns the result it must give.
	function automatic outcome_t schedule_step(logic [1:0] op, logic [15:0] id,
			logic [15:0] arrival, logic [15:0] burst, logic [7:0] urgency);
		outcome_t    r;
		int          chosen;
		int          s;
		logic [15:0] end_t;
		logic [15:0] ta;
		r = '0;
		chosen = -1;
		case (op)
		MODE_LOAD: begin
			if (loaded_tasks >= MAX_TASKS) begin
				r.status = STAT_FULL;
			end else begin
				task_table[loaded_tasks].id        = id;
				task_table[loaded_tasks].arrival   = arrival;
				task_table[loaded_tasks].burst     = burst;
				task_table[loaded_tasks].remaining = burst;
				task_table[loaded_tasks].urgency   = urgency;
				loaded_tasks++;
				r.status = STAT_DONE;
			end
		end
		MODE_CLEAR: begin
			loaded_tasks = 0;
			sched_clock = '0;
			prev_slot = '0;
			prev_busy = 1'b0;
			r.status = STAT_DONE;
		end
		MODE_TICK: begin
			// Pick the best task that has arrived and still has time left.
			for (s = 0; s < loaded_tasks; s++) begin
				if (task_table[s].arrival <= sched_clock && task_table[s].remaining != 0) begin
					if (chosen < 0 || outranks(task_table[s], task_table[chosen]))
						chosen = s;
				end
			end
			end_t = (sched_clock < CLOCK_MAX) ? sched_clock + 16'd1 : CLOCK_MAX;
			r.tick_start = sched_clock;
			if (chosen < 0) begin
				r.status = STAT_IDLE;
				prev_busy = 1'b0;
			end else begin
				r.status = STAT_RAN;
				r.running_id = task_table[chosen].id;
				r.switched = !prev_busy || prev_slot != SLOT_W'(chosen);
				task_table[chosen].remaining = task_table[chosen].remaining - 16'd1;
				if (task_table[chosen].remaining == 16'd0) begin
					ta = end_t - task_table[chosen].arrival;
					r.completed = 1'b1;
					r.turnaround = ta;
					// A saturated clock can leave the turnaround below the burst.
					r.wait_time = (ta > task_table[chosen].burst) ?
						ta - task_table[chosen].burst : 16'd0;
				end
				prev_slot = SLOT_W'(chosen);
				prev_busy = 1'b1;
			end
			sched_clock = end_t;
		end
		default: begin
			// The spare code is ignored and answers with an all-zero result.
			r = '0;
		end
		endcase
		return r;
	endfunction

	// Reports one failure in full while the report budget lasts.
	task automatic log_failure(string what, outcome_t exp_v, outcome_t act_v);
		mismatch_count++;
		if (mismatch_count <= 10) begin
			$display("[%0t] %s", $realtime, what);
			$display("  expected: status=%0d id=%h sw=%0d start=%h cmp=%0d ta=%h wait=%h",
				exp_v.status, exp_v.running_id, exp_v.switched, exp_v.tick_start,
				exp_v.completed, exp_v.turnaround, exp_v.wait_time);
			$display("  actual:   status=%0d id=%h sw=%0d start=%h cmp=%0d ta=%h wait=%h",
				act_v.status, act_v.running_id, act_v.switched, act_v.tick_start,
				act_v.completed, act_v.turnaround, act_v.wait_time);
		end
	endtask

	// Results are compared before a new command is predicted in the same cycle.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			loaded_tasks = 0;
			sched_clock = '0;
			prev_slot = '0;
			prev_busy = 1'b0;
			expected_outcomes.delete();
			mismatch_count = 0;
			outstanding = 0;
		end else begin
			if (done) begin
				got = '{status, running_id, switched, tick_start, completed, turnaround,
					wait_time};
				if (expected_outcomes.size() == 0) begin
					log_failure("result transfer with nothing expected", '0, got);
				end else begin
					want = expected_outcomes.pop_front();
					if (want !== got)
						log_failure("result transfer differs", want, got);
				end
			end
			if (start && !busy)
				expected_outcomes.push_back(schedule_step(mode, new_id, new_arrival,
					new_burst, new_priority));
			outstanding = expected_outcomes.size();
		end
	end

endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Priority scheduler testbench
// Drives directed and random command sequences with random gaps into the
// scheduler and gives the verdict from the failure and outstanding counts
// of the result checker.
// ----------------------------------------------------------------------------
module testbench;
	import pps_pkg::*;

	// The unused fourth code on the mode field.
	localparam logic [1:0] MODE_SPARE = 2'd3;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic [1:0]  mode = MODE_LOAD;
	logic [15:0] new_id = '0;
	logic [15:0] new_arrival = '0;
	logic [15:0] new_burst = '0;
	logic [7:0]  new_priority = '0;
	logic        busy;
	logic        done;
	logic [1:0]  status;
	logic [15:0] running_id;
	logic        switched;
	logic [15:0] tick_start;
	logic        completed;
	logic [15:0] turnaround;
	logic [15:0] wait_time;
	int          mismatch_count;
	int          outstanding;

	bit          gaps_on = 1'b1;
	int          calm_left = 0;
	int          commands_sent = 0;
	logic [15:0] approx_clock = '0;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	preemptive_priority_scheduler_top dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .mode(mode),
		.new_id(new_id), .new_arrival(new_arrival), .new_burst(new_burst),
		.new_priority(new_priority), .done(done), .status(status),
		.running_id(running_id), .switched(switched), .tick_start(tick_start),
		.completed(completed), .turnaround(turnaround), .wait_time(wait_time)
	);

	pps_result_checker result_chk (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .mode(mode),
		.new_id(new_id), .new_arrival(new_arrival), .new_burst(new_burst),
		.new_priority(new_priority), .done(done), .status(status),
		.running_id(running_id), .switched(switched), .tick_start(tick_start),
		.completed(completed), .turnaround(turnaround), .wait_time(wait_time),
		.mismatch_count(mismatch_count), .outstanding(outstanding)
	);

	// Presents one command after a random gap and waits for its transfer.
	task automatic issue(logic [1:0] op, logic [15:0] id, logic [15:0] arrival,
			logic [15:0] burst, logic [7:0] urgency);
		int gap;
		gap = 0;
		if (gaps_on) begin
			if (calm_left > 0)
				calm_left--;
			else if ($urandom_range(0, 29) == 0)
				calm_left = $urandom_range(15, 60);
			else
				gap = $urandom_range(0, 12);
		end
		repeat (gap) begin
			@(negedge clk);
			start <= 1'b0;
		end
		@(negedge clk);
		start <= 1'b1;
		mode <= op;
		new_id <= id;
		new_arrival <= arrival;
		new_burst <= burst;
		new_priority <= urgency;
		do @(posedge clk); while (busy);
		commands_sent++;
		// Rough clock tracking, only to aim arrival times near the present.
		if (op == MODE_CLEAR)
			approx_clock = '0;
		else if (op == MODE_TICK && approx_clock != CLOCK_MAX)
			approx_clock++;
	endtask

	task automatic load(logic [15:0] id, logic [15:0] arrival, logic [15:0] burst,
			logic [7:0] urgency);
		issue(MODE_LOAD, id, arrival, burst, urgency);
	endtask

	// Tick and clear carry junk payload, which the block must ignore.
	task automatic tick();
		issue(MODE_TICK, 16'($urandom), 16'($urandom), 16'($urandom), 8'($urandom));
	endtask

	task automatic clear();
		issue(MODE_CLEAR, 16'($urandom), 16'($urandom), 16'($urandom), 8'($urandom));
	endtask

	// Small ids and priorities often, so that the tie-breaks get exercised.
	function automatic logic [15:0] pick_id();
		return ($urandom_range(0, 1) == 0) ? 16'($urandom_range(0, 7)) : 16'($urandom);
	endfunction

	function automatic logic [7:0] pick_urgency();
		return ($urandom_range(0, 9) < 6) ? 8'($urandom_range(0, 3)) : 8'($urandom);
	endfunction

	// A task set followed by enough ticks to work most of it off, with the
	// odd late arrival loaded mid-run to force preemption.
	task automatic run_task_set();
		int          n_tasks;
		int          n_ticks;
		int          work;
		int          k;
		int          pick;
		logic [15:0] arrival;
		logic [15:0] burst;
		if ($urandom_range(0, 99) < 85)
			clear();
		n_tasks = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 34) : $urandom_range(1, 8);
		work = 0;
		for (k = 0; k < n_tasks; k++) begin
			pick = $urandom_range(0, 99);
			if (pick < 90)
				burst = 16'($urandom_range(1, 5));
			else if (pick < 95)
				burst = 16'd0;
			else
				burst = 16'($urandom);
			if (burst < 16'd8)
				work += burst;
			arrival = ($urandom_range(0, 9) == 0) ? 16'($urandom) :
				16'(approx_clock + $urandom_range(0, 12));
			load(pick_id(), arrival, burst, pick_urgency());
		end
		n_ticks = ((work > 48) ? 48 : work) + $urandom_range(0, 6);
		for (k = 0; k < n_ticks; k++) begin
			if ($urandom_range(0, 9) == 0)
				load(pick_id(), 16'(approx_clock + $urandom_range(0, 2)),
					16'($urandom_range(1, 4)), pick_urgency());
			tick();
		end
	endtask

	initial begin : stimulus
		int waited;
		int k;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed part: empty tick, the spare code, field extremes, a task
		// with no burst, preemption and the id tie-break of the selection.
		tick();
		issue(MODE_SPARE, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF);
		load(16'hFFFF, 16'd0, 16'd2, 8'hFF);
		load(16'h0000, 16'd0, 16'd0, 8'h00);
		load(16'h0009, 16'd2, 16'd1, 8'h00);
		load(16'h0009, 16'd1, 16'd1, 8'd10);
		load(16'h0004, 16'd1, 16'd1, 8'd10);
		load(16'h0004, 16'd1, 16'd1, 8'd10);
		for (k = 0; k < 8; k++)
			tick();
		load(16'hAAAA, 16'hFFFF, 16'hFFFF, 8'h80);
		tick();
		clear();
		tick();
		load(16'h5555, 16'd0, 16'd1, 8'h00);
		tick();

		// Random part: mostly well-formed task sets, some raw noise.
		while (commands_sent < 1400) begin
			if ($urandom_range(0, 99) < 8)
				issue(2'($urandom_range(0, 3)), 16'($urandom), 16'($urandom),
					16'($urandom), 8'($urandom));
			else
				run_task_set();
		end

		// Close with a short back-to-back run over a fresh table.
		gaps_on = 1'b0;
		clear();
		load(16'h0101, 16'd0, 16'd3, 8'd5);
		load(16'h0202, 16'd2, 16'd10, 8'd5);
		load(16'h0303, 16'd4, 16'd2, 8'd1);
		for (k = 0; k < 20; k++)
			tick();

		@(negedge clk);
		start <= 1'b0;
		waited = 0;
		while (outstanding != 0 && waited < 2000) begin
			@(posedge clk);
			waited++;
		end
		repeat (64) @(posedge clk);
		if (mismatch_count == 0 && outstanding == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// Run limit, far above the slowest correct run.
	initial begin : watchdog
		#5_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

@@ filelist.f @@
sv/pps_pkg.sv
sv/preemptive_priority_scheduler_top.sv
sv/pps_checker.sv
sim/pps_result_checker.sv
sim/testbench.sv
